// File: rtl/core/bbd_pkg.sv
`timescale 1ns / 1ps
// bbd_pkg: shared constants and types of the RGGB bilinear demosaic.
// No dependencies; used by bayer_bilinear_demosaic.
package bbd_pkg;

	localparam int PIX_W         = 8;
	localparam int CFG_W         = 13;
	localparam int CFG_IDX_W     = 1;
	localparam int ROW_W         = 13;
	localparam int MAX_WIDTH_DEF = 4096;
	localparam int HEIGHT_LIMIT  = 4096;

	localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 13'd1280;
	localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 13'd960;

	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

	// one vertical 3-pixel column: [0] top, [1] middle, [2] bottom
	typedef logic [2:0][PIX_W-1:0] col_t;

	// per-beat geometry flags, worked out at the input
	typedef struct packed {
		logic emit;
		logic left_clamp;
		logic right_clamp;
		logic top_clamp;
		logic bot_clamp;
		logic even_row;
		logic even_col;
		logic eof;
	} ctl_t;

endpackage

// File: rtl/core/bayer_bilinear_demosaic.sv
`timescale 1ns / 1ps
// A result is registered in stages 1, 2 and 3 after the beat that completes it is accepted.
// Throughput: one beat per cycle unless out_ready stalls; each beat reads both line buffers at
// one column (one read, one write port each), forwarding from the beat ahead at the same column.
// Reset: position counters, window and pipeline valids clear, width/height go to 1280/960;
// line buffers are not cleared.
// bayer_bilinear_demosaic: streaming RGGB bilinear demosaic with two line buffers.
// Depends on bbd_pkg.
module bayer_bilinear_demosaic #(
	parameter int MAX_WIDTH = bbd_pkg::MAX_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [bbd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bbd_pkg::CFG_W-1:0]       cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [bbd_pkg::PIX_W-1:0]       raw_pixel,
	input  logic                            pixel_present,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [bbd_pkg::PIX_W-1:0]       red,
	output logic [bbd_pkg::PIX_W-1:0]       green,
	output logic [bbd_pkg::PIX_W-1:0]       blue,
	output logic                            end_of_frame
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = CW + 1;
	localparam int EW = (WW > bbd_pkg::CFG_W) ? WW : bbd_pkg::CFG_W;
	localparam int RW = bbd_pkg::ROW_W;
	localparam int PW = bbd_pkg::PIX_W;

	// configuration
	logic [bbd_pkg::CFG_W-1:0] width_q, height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= bbd_pkg::FRAME_WIDTH_RST;
			height_q <= bbd_pkg::FRAME_HEIGHT_RST;
		end else if (cfg_write) begin
			if (cfg_index == bbd_pkg::CFG_FRAME_WIDTH)
				width_q <= cfg_data;
			if (cfg_index == bbd_pkg::CFG_FRAME_HEIGHT)
				height_q <= cfg_data;
		end
	end

	logic [EW-1:0] wreg_ext;
	logic [WW-1:0] w_eff;
	logic [RW-1:0] h_eff;
	logic [RW:0]   h_p1;

	assign wreg_ext = EW'(width_q);
	assign w_eff = (width_q == '0) ? WW'(1) :
		(wreg_ext > EW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(wreg_ext);
	assign h_eff = (height_q == '0) ? RW'(1) :
		(height_q > RW'(bbd_pkg::HEIGHT_LIMIT)) ? RW'(bbd_pkg::HEIGHT_LIMIT) : height_q;
	assign h_p1 = {1'b0, h_eff} + (RW+1)'(1);

	// handshake
	logic v_s1, v_s2, v_s3;
	logic en_s2, en_s3, adv_s1, in_fire, wr_en;

	assign en_s3    = !v_s3 || out_ready;
	assign en_s2    = !v_s2 || en_s3;
	assign adv_s1   = v_s1 && en_s2;
	assign in_ready = !v_s1 || en_s2;
	assign in_fire  = in_valid && in_ready;
	assign wr_en    = adv_s1;

	// raster position of the next beat
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [WW-1:0] c_ext, c_p1;
	logic [RW:0]   r_ext;
	logic          c0;
	bbd_pkg::ctl_t ctl_in;

	assign c_ext = {1'b0, col_q};
	assign c_p1  = c_ext + WW'(1);
	assign r_ext = {1'b0, row_q};
	assign c0    = (col_q == '0);

	always_comb begin
		ctl_in.emit        = c0 ? (row_q >= RW'(2)) : (row_q != '0);
		ctl_in.left_clamp  = c0 ? (w_eff == WW'(1)) : (col_q == CW'(1));
		ctl_in.right_clamp = c0 ? 1'b1 : (c_ext >= w_eff);
		ctl_in.top_clamp   = c0 ? (row_q == RW'(2)) : (row_q == RW'(1));
		ctl_in.bot_clamp   = c0 ? (r_ext >= h_p1) : (row_q >= h_eff);
		ctl_in.even_row    = c0 ? !row_q[0] : row_q[0];
		ctl_in.even_col    = c0 ? w_eff[0] : col_q[0];
		ctl_in.eof         = c0 ? (r_ext == h_p1) : ((row_q == h_eff) && (c_ext == w_eff));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_fire) begin
			if (r_ext >= h_p1) begin
				col_q <= '0;
				row_q <= '0;
			end else if (c_p1 >= w_eff) begin
				col_q <= '0;
				row_q <= row_q + RW'(1);
			end else begin
				col_q <= CW'(c_p1);
			end
		end
	end

	// stage 1: line buffer read, resolve against the write in flight
	bbd_pkg::ctl_t ctl_s1;
	logic [PW-1:0] d_s1, rd_old_s1, rd_mid_s1, fwd_old_s1, fwd_mid_s1;
	logic [PW-1:0] top_res, mid_res;
	logic [CW-1:0] c_s1;
	logic          fwd_s1;
	logic [PW-1:0] older_mem [MAX_WIDTH];
	logic [PW-1:0] middle_mem [MAX_WIDTH];

	assign top_res = fwd_s1 ? fwd_old_s1 : rd_old_s1;
	assign mid_res = fwd_s1 ? fwd_mid_s1 : rd_mid_s1;

	always_ff @(posedge clk) begin
		if (wr_en)
			older_mem[c_s1] <= mid_res;
		if (in_fire)
			rd_old_s1 <= older_mem[col_q];
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			middle_mem[c_s1] <= d_s1;
		if (in_fire)
			rd_mid_s1 <= middle_mem[col_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			fwd_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1   <= in_valid;
			fwd_s1 <= wr_en && (c_s1 == col_q);
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			ctl_s1     <= ctl_in;
			c_s1       <= col_q;
			d_s1       <= pixel_present ? raw_pixel : '0;
			fwd_old_s1 <= mid_res;
			fwd_mid_s1 <= d_s1;
		end
	end

	// window of the last three columns, [2] newest
	bbd_pkg::col_t win_q [3];
	bbd_pkg::col_t newcol;

	assign newcol = {d_s1, mid_res, top_res};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q[0] <= '0;
			win_q[1] <= '0;
			win_q[2] <= '0;
		end else if (adv_s1) begin
			win_q[0] <= win_q[1];
			win_q[1] <= win_q[2];
			win_q[2] <= newcol;
		end
	end

	// stage 2: clamped 3x3 neighborhood
	bbd_pkg::ctl_t ctl_s2;
	bbd_pkg::col_t cols_s2 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (en_s2)
			v_s2 <= adv_s1 && ctl_s1.emit;
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && en_s2) begin
			ctl_s2     <= ctl_s1;
			cols_s2[0] <= ctl_s1.left_clamp ? win_q[2] : win_q[1];
			cols_s2[1] <= win_q[2];
			cols_s2[2] <= ctl_s1.right_clamp ? win_q[2] : newcol;
		end
	end

	logic [PW-1:0] g0 [3];
	logic [PW-1:0] g1 [3];
	logic [PW-1:0] g2 [3];
	logic [PW+1:0] cross_sum, diag_sum;
	logic [PW:0]   horiz_sum, vert_sum;
	logic [PW-1:0] cross_avg, diag_avg, horiz_avg, vert_avg;
	logic [PW-1:0] r_nx, g_nx, b_nx;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			g1[k] = cols_s2[k][1];
			g0[k] = ctl_s2.top_clamp ? cols_s2[k][1] : cols_s2[k][0];
			g2[k] = ctl_s2.bot_clamp ? cols_s2[k][1] : cols_s2[k][2];
		end
		cross_sum = (PW+2)'(g1[0]) + (PW+2)'(g1[2]) + (PW+2)'(g0[1]) + (PW+2)'(g2[1]);
		diag_sum  = (PW+2)'(g0[0]) + (PW+2)'(g0[2]) + (PW+2)'(g2[0]) + (PW+2)'(g2[2]);
		horiz_sum = (PW+1)'(g1[0]) + (PW+1)'(g1[2]);
		vert_sum  = (PW+1)'(g0[1]) + (PW+1)'(g2[1]);
		cross_avg = cross_sum[PW+1:2];
		diag_avg  = diag_sum[PW+1:2];
		horiz_avg = horiz_sum[PW:1];
		vert_avg  = vert_sum[PW:1];
		if (ctl_s2.even_row && ctl_s2.even_col) begin
			r_nx = g1[1];
			g_nx = cross_avg;
			b_nx = diag_avg;
		end else if (ctl_s2.even_row) begin
			r_nx = horiz_avg;
			g_nx = g1[1];
			b_nx = vert_avg;
		end else if (ctl_s2.even_col) begin
			r_nx = vert_avg;
			g_nx = g1[1];
			b_nx = horiz_avg;
		end else begin
			r_nx = diag_avg;
			g_nx = cross_avg;
			b_nx = g1[1];
		end
	end

	// stage 3: output register
	logic [PW-1:0] red_s3, green_s3, blue_s3;
	logic          eof_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else if (en_s3)
			v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (v_s2 && en_s3) begin
			red_s3   <= r_nx;
			green_s3 <= g_nx;
			blue_s3  <= b_nx;
			eof_s3   <= ctl_s2.eof;
		end
	end

	assign out_valid    = v_s3;
	assign red          = red_s3;
	assign green        = green_s3;
	assign blue         = blue_s3;
	assign end_of_frame = eof_s3;

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// tb: self-checking testbench of bayer_bilinear_demosaic (RGGB bilinear demosaic).
// Streams raw frames of many geometries with random stalls and checks every RGB beat
// against a line-buffer predictor held in a scoreboard class. Depends on bbd_pkg.
module tb;

	localparam int MAX_W       = bbd_pkg::MAX_WIDTH_DEF;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int RAND_ITEMS  = 1200;

	typedef struct packed {
		logic [bbd_pkg::PIX_W-1:0] red;
		logic [bbd_pkg::PIX_W-1:0] green;
		logic [bbd_pkg::PIX_W-1:0] blue;
		logic                      eof;
	} rgb_pix_t;

	class demosaic_scoreboard;
		logic [bbd_pkg::CFG_W-1:0] width_reg;
		logic [bbd_pkg::CFG_W-1:0] height_reg;
		logic [bbd_pkg::PIX_W-1:0] older_row [MAX_W];
		logic [bbd_pkg::PIX_W-1:0] middle_row [MAX_W];
		bbd_pkg::col_t             window [3];
		int unsigned               in_col;
		int unsigned               in_row;
		rgb_pix_t                  pending_rgb [$];
		int                        errors;

		function new();
			width_reg  = bbd_pkg::FRAME_WIDTH_RST;
			height_reg = bbd_pkg::FRAME_HEIGHT_RST;
			foreach (older_row[i]) begin
				older_row[i]  = '0;
				middle_row[i] = '0;
			end
			foreach (window[i])
				window[i] = '0;
			in_col = 0;
			in_row = 0;
			errors = 0;
		endfunction

		function int unsigned cols_eff();
			if (width_reg == 0)
				return 1;
			if (width_reg > MAX_W)
				return MAX_W;
			return 32'(width_reg);
		endfunction

		function int unsigned rows_eff();
			if (height_reg == 0)
				return 1;
			if (height_reg > bbd_pkg::HEIGHT_LIMIT)
				return bbd_pkg::HEIGHT_LIMIT;
			return 32'(height_reg);
		endfunction

		function void set_reg(logic [bbd_pkg::CFG_IDX_W-1:0] idx,
				logic [bbd_pkg::CFG_W-1:0] value);
			if (idx == bbd_pkg::CFG_FRAME_WIDTH)
				width_reg = value;
			else if (idx == bbd_pkg::CFG_FRAME_HEIGHT)
				height_reg = value;
		endfunction

		// 3x3 neighborhood from three columns, edges clamped, then RGGB phase select
		function rgb_pix_t interpolate_rgb(bbd_pkg::col_t cl, bbd_pkg::col_t cc,
				bbd_pkg::col_t cr, int unsigned oy, int unsigned ox, int unsigned w,
				int unsigned h);
			bbd_pkg::col_t k [3];
			logic [9:0]    cross_sum;
			logic [9:0]    diag_sum;
			logic [8:0]    horiz_sum;
			logic [8:0]    vert_sum;
			rgb_pix_t      p;
			k[0] = (ox == 0) ? cc : cl;
			k[1] = cc;
			k[2] = (ox + 1 >= w) ? cc : cr;
			foreach (k[j]) begin
				if (oy == 0)
					k[j][0] = k[j][1];
				if (oy + 1 >= h)
					k[j][2] = k[j][1];
			end
			cross_sum = {2'b00, k[0][1]} + {2'b00, k[2][1]} + {2'b00, k[1][0]}
				+ {2'b00, k[1][2]};
			diag_sum  = {2'b00, k[0][0]} + {2'b00, k[2][0]} + {2'b00, k[0][2]}
				+ {2'b00, k[2][2]};
			horiz_sum = {1'b0, k[0][1]} + {1'b0, k[2][1]};
			vert_sum  = {1'b0, k[1][0]} + {1'b0, k[1][2]};
			p.eof = (oy + 1 == h) && (ox + 1 == w);
			case ({oy[0], ox[0]})
				2'b00: begin
					p.red   = k[1][1];
					p.green = cross_sum[9:2];
					p.blue  = diag_sum[9:2];
				end
				2'b01: begin
					p.red   = horiz_sum[8:1];
					p.green = k[1][1];
					p.blue  = vert_sum[8:1];
				end
				2'b10: begin
					p.red   = vert_sum[8:1];
					p.green = k[1][1];
					p.blue  = horiz_sum[8:1];
				end
				default: begin
					p.red   = diag_sum[9:2];
					p.green = cross_sum[9:2];
					p.blue  = k[1][1];
				end
			endcase
			return p;
		endfunction

		function void take_raw_beat(logic [bbd_pkg::PIX_W-1:0] raw, logic present);
			int unsigned               w;
			int unsigned               h;
			int unsigned               c;
			int unsigned               r;
			int unsigned               idx;
			logic [bbd_pkg::PIX_W-1:0] d;
			logic [bbd_pkg::PIX_W-1:0] top;
			logic [bbd_pkg::PIX_W-1:0] mid;
			bbd_pkg::col_t             prev1;
			bbd_pkg::col_t             prev2;
			w = cols_eff();
			h = rows_eff();
			c = in_col;
			r = in_row;
			d = present ? raw : '0;
			idx = (c < MAX_W) ? c : MAX_W - 1;
			top = older_row[idx];
			mid = middle_row[idx];
			older_row[idx]  = mid;
			middle_row[idx] = d;
			prev1 = window[1];
			prev2 = window[2];
			window[0] = window[1];
			window[1] = window[2];
			window[2] = {d, mid, top};
			if (c == 0) begin
				if (r >= 2)
					pending_rgb.push_back(interpolate_rgb(prev1, prev2, prev2, r - 2, w - 1,
						w, h));
			end else if (r >= 1) begin
				pending_rgb.push_back(interpolate_rgb(window[0], window[1], window[2], r - 1,
					c - 1, w, h));
			end
			if (r >= h + 1) begin
				in_row = 0;
				in_col = 0;
			end else if (c + 1 >= w) begin
				in_col = 0;
				in_row = r + 1;
			end else begin
				in_col = c + 1;
			end
		endfunction

		function void check_rgb_beat(logic [bbd_pkg::PIX_W-1:0] r,
				logic [bbd_pkg::PIX_W-1:0] g, logic [bbd_pkg::PIX_W-1:0] b, logic eof);
			rgb_pix_t want;
			if (pending_rgb.size() == 0) begin
				errors++;
				$display("%0t: unexpected beat, expected none, got r=%0d g=%0d b=%0d eof=%0b",
					$time, r, g, b, eof);
				return;
			end
			want = pending_rgb.pop_front();
			if (r !== want.red) begin
				errors++;
				$display("%0t: red expected %0d, got %0d", $time, want.red, r);
			end
			if (g !== want.green) begin
				errors++;
				$display("%0t: green expected %0d, got %0d", $time, want.green, g);
			end
			if (b !== want.blue) begin
				errors++;
				$display("%0t: blue expected %0d, got %0d", $time, want.blue, b);
			end
			if (eof !== want.eof) begin
				errors++;
				$display("%0t: end_of_frame expected %0b, got %0b", $time, want.eof, eof);
			end
		endfunction
	endclass

	logic                          clk           = 1'b0;
	logic                          arst_n        = 1'b0;
	logic                          cfg_write     = 1'b0;
	logic [bbd_pkg::CFG_IDX_W-1:0] cfg_index     = bbd_pkg::CFG_FRAME_WIDTH;
	logic [bbd_pkg::CFG_W-1:0]     cfg_data      = '0;
	logic                          in_valid      = 1'b0;
	logic                          in_ready;
	logic [bbd_pkg::PIX_W-1:0]     raw_pixel     = '0;
	logic                          pixel_present = 1'b0;
	logic                          out_valid;
	logic                          out_ready     = 1'b0;
	logic [bbd_pkg::PIX_W-1:0]     red;
	logic [bbd_pkg::PIX_W-1:0]     green;
	logic [bbd_pkg::PIX_W-1:0]     blue;
	logic                          end_of_frame;

	bit                            calm          = 1'b0;
	int                            ready_hold    = 0;
	int                            cycles        = 0;
	demosaic_scoreboard            sb;

	bayer_bilinear_demosaic i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.raw_pixel    (raw_pixel),
		.pixel_present(pixel_present),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.end_of_frame (end_of_frame)
	);

	always #2 clk = ~clk;

	function automatic int stall_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 75)
			return $urandom_range(1, 3);
		if (p < 95)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic int sender_gap();
		if (calm || $urandom_range(0, 99) < 55)
			return 0;
		return stall_len();
	endfunction

	function automatic logic [bbd_pkg::PIX_W-1:0] pick_raw();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return bbd_pkg::PIX_W'($urandom_range(0, 255));
		endcase
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_rgb_beat(red, green, blue, end_of_frame);
			if (in_valid && in_ready)
				sb.take_raw_beat(raw_pixel, pixel_present);
			if (cfg_write)
				sb.set_reg(cfg_index, cfg_data);
		end
	end

	always @(negedge clk) begin
		if (ready_hold > 0) begin
			ready_hold = ready_hold - 1;
			out_ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 4) == 0) begin
			ready_hold = stall_len() - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic push_beat(input logic [bbd_pkg::PIX_W-1:0] value, input logic present);
		int gap;
		in_valid      <= 1'b1;
		raw_pixel     <= value;
		pixel_present <= present;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
		gap = sender_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// hold the source until every pixel is out, then let the pipeline settle
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (sb.pending_rgb.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic set_geometry(input logic [bbd_pkg::CFG_W-1:0] w,
			input logic [bbd_pkg::CFG_W-1:0] h);
		cfg_write <= 1'b1;
		cfg_index <= bbd_pkg::CFG_FRAME_WIDTH;
		cfg_data  <= w;
		@(negedge clk);
		cfg_index <= bbd_pkg::CFG_FRAME_HEIGHT;
		cfg_data  <= h;
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	// feeds beats until the frame closes; rows past the frame are flush beats
	task automatic run_frame(input bit noisy, input bit flush_pixels, input bit alt_levels,
			output int n_items);
		logic                      present;
		logic [bbd_pkg::PIX_W-1:0] value;
		n_items = 0;
		do begin
			if (sb.in_row < sb.rows_eff())
				present = !(noisy && $urandom_range(0, 15) == 0);
			else
				present = flush_pixels || (noisy && $urandom_range(0, 3) == 0);
			if (alt_levels)
				value = ((sb.in_row ^ sb.in_col) & 1) ? '1 : '0;
			else
				value = pick_raw();
			push_beat(value, present);
			n_items++;
		end while (sb.in_row != 0 || sb.in_col != 0);
	endtask

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Some tests failed");
		$finish;
	end

	initial begin
		int n;
		int rand_items;
		int frame_no;
		int ext_idx;
		bit force_cfg;
		bit noisy;
		sb = new();
		rand_items = 0;
		frame_no   = 0;
		ext_idx    = 0;
		force_cfg  = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// zero geometry counts as one pixel; flush beats carry pixels
		set_geometry('0, '0);
		run_frame(1'b0, 1'b1, 1'b1, n);
		wait_idle();
		set_geometry(13'd4, 13'd3);
		run_frame(1'b0, 1'b1, 1'b1, n);

		// shrink width and height in the middle of a frame
		wait_idle();
		set_geometry(13'd3, 13'd3);
		repeat (5) push_beat(pick_raw(), 1'b1);
		wait_idle();
		set_geometry(13'd2, 13'd2);
		run_frame(1'b0, 1'b0, 1'b0, n);

		while (rand_items < RAND_ITEMS) begin
			if (frame_no % 6 == 2 && ext_idx < 4) begin
				wait_idle();
				case (ext_idx)
					0: set_geometry(13'd7, 13'd0);
					1: set_geometry(13'd0, 13'd5);
					2: set_geometry(13'd1, 13'd1);
					default: set_geometry(13'd2, 13'd0);
				endcase
				calm = 1'b1;
				run_frame(1'b0, 1'b0, 1'b0, n);
				calm = 1'b0;
				ext_idx++;
				force_cfg = 1'b1;
				rand_items += n;
			end else begin
				if (force_cfg || $urandom_range(0, 2) == 0) begin
					wait_idle();
					set_geometry(bbd_pkg::CFG_W'(($urandom_range(0, 3) == 0)
						? $urandom_range(13, 64) : $urandom_range(1, 12)),
						bbd_pkg::CFG_W'($urandom_range(1, 6)));
					force_cfg = 1'b0;
				end
				calm  = ($urandom_range(0, 4) == 0);
				noisy = ($urandom_range(0, 3) == 0);
				run_frame(noisy, noisy && $urandom_range(0, 1) == 0, 1'b0, n);
				calm = 1'b0;
				rand_items += n;
			end
			frame_no++;
		end

		wait_idle();
		repeat (16) @(negedge clk);
		if (sb.errors == 0 && sb.pending_rgb.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
